### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, constants and register indexes for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int RAW_W   = 20;
  localparam int FINE_W  = 32;
  localparam int CENTI_W = 27;
  localparam int PRESS_W = 32;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 2;
  localparam int WIDE_W  = 64;

  localparam int IN_W    = 40;   // two raw fields, already whole bytes
  localparam int OUT_W   = 96;   // fine, centi, pressure, zero pad

  typedef enum logic [IDX_W-1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_t;

  localparam logic [WIDE_W-1:0] FINE_OFFSET = 64'd128000;
  localparam logic [RAW_W:0]    PRESS_BASE  = 21'd1048576;
  localparam logic [WIDE_W-1:0] PRESS_SCALE = 64'd3125;

  // stage budget: temperature 6, pressure terms 8, divide 66, tail 6
  localparam int DIV_LAT  = WIDE_W + 2;
  localparam int PIPE_LAT = 14 + DIV_LAT + 6;

endpackage

`default_nettype wire

### rtl/bpc_dly.sv
// ----------------------------------------------------------------------------
// bpc_dly
// Shift line that keeps side data aligned with the pipeline; moves on en.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] sh [D];

  always_ff @(posedge clk) begin
    if (en) begin
      sh[0] <= din;
    end
  end

  for (genvar i = 1; i < D; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        sh[i] <= sh[i-1];
      end
    end
  end

  assign dout = sh[D-1];

endmodule

`default_nettype wire

### rtl/bpc_mul64.sv
// ----------------------------------------------------------------------------
// bpc_mul64
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// Two stages; wrapping result is the same for signed and unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_mul64 import bpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [WIDE_W-1:0] a,
  input  wire logic [WIDE_W-1:0] b,
  output logic      [WIDE_W-1:0] p
);

  localparam int H = WIDE_W / 2;

  logic [WIDE_W-1:0] pll;
  logic [H-1:0]      plh;
  logic [H-1:0]      phl;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[H-1:0] * b[H-1:0];
      plh <= H'(a[H-1:0] * b[WIDE_W-1:H]);
      phl <= H'(a[WIDE_W-1:H] * b[H-1:0]);
      p   <= pll + {plh + phl, {H{1'b0}}};
    end
  end

endmodule

`default_nettype wire

### rtl/bpc_div64.sv
// ----------------------------------------------------------------------------
// bpc_div64
// Pipelined signed divide, truncating toward zero: sign stage, one
// restoring step per stage, sign fix stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div64 import bpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [WIDE_W-1:0] num,
  input  wire logic [WIDE_W-1:0] den,
  output logic      [WIDE_W-1:0] quo
);

  localparam int W = WIDE_W;

  logic [W-1:0] rem [W+1];
  logic [W-1:0] dq  [W+1];
  logic [W-1:0] dd  [W+1];
  logic         ng  [W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dq[0]  <= num[W-1] ? (~num + 1'b1) : num;
      dd[0]  <= den[W-1] ? (~den + 1'b1) : den;
      ng[0]  <= num[W-1] ^ den[W-1];
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W:0] trial;
    assign trial = {rem[i], dq[i][W-1]} - {1'b0, dd[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= trial[W] ? {rem[i][W-2:0], dq[i][W-1]} : trial[W-1:0];
        dq[i+1]  <= {dq[i][W-2:0], ~trial[W]};
        dd[i+1]  <= dd[i];
        ng[i+1]  <= ng[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[W] ? (~dq[W] + 1'b1) : dq[W];
    end
  end

endmodule

`default_nettype wire

### rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer temperature and pressure compensation of raw sensor beats.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output beat is not held; the
// divider sets the depth.
// Whole pipeline stalls together only while the output beat is held.
// Reset (synchronous rst) clears valid bits and coefficients to zero.
`default_nettype none

module baro_pressure_temp_compensation import bpc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_W-1:0]     s_tdata,   // raw_temperature, raw_pressure
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_W-1:0]         m_tdata,   // fine_temperature, temperature_centi,
                                              // pressure_q24_8, zero pad
  output logic [0:0]               m_tuser,   // pressure_valid
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  logic [CFG_W-1:0] cfg_t, cfg_a, cfg_b, cfg_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_t <= '0;
      cfg_a <= '0;
      cfg_b <= '0;
      cfg_c <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEMP:    cfg_t <= cfg_data;
        REG_PRESS_A: cfg_a <= cfg_data;
        REG_PRESS_B: cfg_b <= cfg_data;
        REG_PRESS_C: cfg_c <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [FINE_W-1:0] t2, t3;
  logic [WIDE_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t2 = {{16{cfg_t[31]}}, cfg_t[31:16]};
  assign t3 = {{16{cfg_t[47]}}, cfg_t[47:32]};
  assign p1 = {48'b0, cfg_a[15:0]};
  assign p2 = {{48{cfg_a[31]}}, cfg_a[31:16]};
  assign p3 = {{48{cfg_a[47]}}, cfg_a[47:32]};
  assign p4 = {{48{cfg_b[15]}}, cfg_b[15:0]};
  assign p5 = {{48{cfg_b[31]}}, cfg_b[31:16]};
  assign p6 = {{48{cfg_b[47]}}, cfg_b[47:32]};
  assign p7 = {{48{cfg_c[15]}}, cfg_c[15:0]};
  assign p8 = {{48{cfg_c[31]}}, cfg_c[31:16]};
  assign p9 = {{48{cfg_c[47]}}, cfg_c[47:32]};

  // pipeline control
  logic                en;
  logic [PIPE_LAT-1:0] vld;

  assign en       = !vld[PIPE_LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], s_tvalid};
    end
  end

  // temperature, stages 1..6
  logic [RAW_W-1:0]  adc_t, adc_p;
  logic [FINE_W-1:0] d1, d2, m1, m2, x1, q, x1b, m3, fine, fine6, f5;
  logic [CENTI_W-1:0] centi6;
  logic [RAW_W:0]    p0, p0d;
  logic [WIDE_W-1:0] v1;

  assign adc_t = s_tdata[RAW_W-1:0];
  assign adc_p = s_tdata[2*RAW_W-1:RAW_W];
  assign f5    = fine + {fine[FINE_W-3:0], 2'b00} + 32'd128;

  always_ff @(posedge clk) begin
    if (en) begin
      d1     <= {15'b0, adc_t[19:3]} - {15'b0, cfg_t[15:0], 1'b0};
      d2     <= {16'b0, adc_t[19:4]} - {16'b0, cfg_t[15:0]};
      p0     <= PRESS_BASE - {1'b0, adc_p};
      m1     <= d1 * t2;
      m2     <= d2 * d2;
      x1     <= 32'($signed(m1) >>> 11);
      q      <= 32'($signed(m2) >>> 12);
      x1b    <= x1;
      m3     <= q * t3;
      fine   <= x1b + 32'($signed(m3) >>> 14);
      fine6  <= fine;
      centi6 <= CENTI_W'($signed(f5) >>> 8);
      v1     <= {{32{fine[31]}}, fine} - FINE_OFFSET;
    end
  end

  // pressure terms, stages 7..14
  logic [WIDE_W-1:0] sq, a5, a2, a5d, a2d, t6, t3m, v2, v1b, diff, num, prod1, den;

  bpc_mul64 u_sq (.clk, .en, .a(v1), .b(v1), .p(sq));
  bpc_mul64 u_a5 (.clk, .en, .a(v1), .b(p5), .p(a5));
  bpc_mul64 u_a2 (.clk, .en, .a(v1), .b(p2), .p(a2));
  bpc_mul64 u_t6 (.clk, .en, .a(sq), .b(p6), .p(t6));
  bpc_mul64 u_t3 (.clk, .en, .a(sq), .b(p3), .p(t3m));
  bpc_dly #(.W(WIDE_W), .D(2)) u_a5d (.clk, .en, .din(a5), .dout(a5d));
  bpc_dly #(.W(WIDE_W), .D(2)) u_a2d (.clk, .en, .din(a2), .dout(a2d));
  bpc_dly #(.W(RAW_W+1), .D(10)) u_p0d (.clk, .en, .din(p0), .dout(p0d));

  always_ff @(posedge clk) begin
    if (en) begin
      v2   <= t6 + {a5d[46:0], 17'b0} + {p4[28:0], 35'b0};
      v1b  <= 64'($signed(t3m) >>> 8) + {a2d[51:0], 12'b0} + (64'd1 << 47);
      diff <= {12'b0, p0d, 31'b0} - v2;
      den  <= 64'($signed(prod1) >>> 33);
    end
  end

  bpc_mul64 u_num (.clk, .en, .a(diff), .b(PRESS_SCALE), .p(num));
  bpc_mul64 u_p1  (.clk, .en, .a(v1b), .b(p1), .p(prod1));

  // divide, stages 15..80
  logic [WIDE_W-1:0] pq, ph, phph, e1, e2, e2d, pqd, s;
  logic              zr;

  bpc_div64 u_div (.clk, .en, .num(num), .den(den), .quo(pq));
  bpc_dly #(.W(1), .D(DIV_LAT+5)) u_zr (.clk, .en, .din(den == '0), .dout(zr));

  // tail, stages 81..86
  assign ph = 64'($signed(pq) >>> 13);

  bpc_mul64 u_phph (.clk, .en, .a(ph), .b(ph), .p(phph));
  bpc_mul64 u_e2   (.clk, .en, .a(pq), .b(p8), .p(e2));
  bpc_mul64 u_e1   (.clk, .en, .a(phph), .b(p9), .p(e1));
  bpc_dly #(.W(WIDE_W), .D(2)) u_e2d (.clk, .en, .din(e2), .dout(e2d));
  bpc_dly #(.W(WIDE_W), .D(4)) u_pqd (.clk, .en, .din(pq), .dout(pqd));

  logic [FINE_W-1:0]  fine_o;
  logic [CENTI_W-1:0] centi_o;
  logic [WIDE_W-1:0]  pfin;

  bpc_dly #(.W(FINE_W), .D(PIPE_LAT-7)) u_fd (.clk, .en, .din(fine6), .dout(fine_o));
  bpc_dly #(.W(CENTI_W), .D(PIPE_LAT-7)) u_cd (.clk, .en, .din(centi6), .dout(centi_o));

  assign pfin = 64'($signed(s) >>> 8) + {p7[59:0], 4'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      s       <= pqd + 64'($signed(e1) >>> 25) + 64'($signed(e2d) >>> 19);
      m_tdata <= {5'b0, zr ? {PRESS_W{1'b0}} : pfin[PRESS_W-1:0], centi_o, fine_o};
      m_tuser <= !zr;
    end
  end

  // checks
  logic [FINE_W-1:0]  chk_f5;
  logic [CENTI_W-1:0] chk_centi;

  always_comb begin
    chk_f5    = m_tdata[31:0] + {m_tdata[29:0], 2'b00} + 32'd128;
    chk_centi = CENTI_W'($signed(chk_f5) >>> 8);
  end

  a_centi: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[58:32] == chk_centi)
    else $error("centi does not match fine temperature");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tdata[90:59] == '0)
    else $error("pressure not forced to zero on zero divisor");

  a_rst: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("valid beat right after reset");

endmodule

`default_nettype wire

### dv/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Watches the raw sample and result streams and the register port. Predicts
// each compensated result and compares it field by field, in order.
// ----------------------------------------------------------------------------
module bpc_checker import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // raw_temperature, raw_pressure
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,   // fine, centi, pressure, zero pad
  input  logic [0:0]        m_tuser,   // pressure_valid
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [FINE_W-1:0]  fine;
    logic [CENTI_W-1:0] centi;
    logic [PRESS_W-1:0] press;
    logic               valid;
  } comp_result_t;

  logic [CFG_W-1:0] coef_t, coef_a, coef_b, coef_c;
  comp_result_t     expected_q[$];

  function automatic logic [63:0] sx16(logic [CFG_W-1:0] r, int k);
    logic [15:0] v;
    v = r[16*k +: 16];
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic comp_result_t compensate(logic [RAW_W-1:0] rt, logic [RAW_W-1:0] rp);
    comp_result_t r;
    logic [31:0] t1, t2, t3, d1, d2, x1, x2, fine, sq;
    logic [63:0] f64, v1, v2, p, ph, e1, e2, na, nb, q;
    t1 = {16'b0, coef_t[15:0]};
    t2 = sx16(coef_t, 1);
    t3 = sx16(coef_t, 2);
    d1 = ({12'b0, rt} >> 3) - (t1 << 1);
    x1 = asr32(d1 * t2, 11);
    d2 = ({12'b0, rt} >> 4) - t1;
    sq = asr32(d2 * d2, 12);
    x2 = asr32(sq * t3, 14);
    fine = x1 + x2;
    r.fine = fine;
    sq = asr32(fine * 32'd5 + 32'd128, 8);
    r.centi = sq[CENTI_W-1:0];
    f64 = {{32{fine[31]}}, fine};
    v1 = f64 - 64'd128000;
    v2 = v1 * v1 * sx16(coef_b, 2);
    v2 = v2 + ((v1 * sx16(coef_b, 1)) << 17);
    v2 = v2 + (sx16(coef_b, 0) << 35);
    v1 = asr64(v1 * v1 * sx16(coef_a, 2), 8) + ((v1 * sx16(coef_a, 1)) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * {48'b0, coef_a[15:0]}, 33);
    r.press = '0;
    r.valid = 1'b0;
    if (v1 != 0) begin
      p = 64'd1048576 - {44'b0, rp};
      p = ((p << 31) - v2) * 64'd3125;
      // truncating divide on magnitudes; min / -1 wraps naturally
      na = p[63] ? -p : p;
      nb = v1[63] ? -v1 : v1;
      q = na / nb;
      p = (p[63] != v1[63]) ? -q : q;
      ph = asr64(p, 13);
      e1 = asr64(sx16(coef_c, 2) * ph * ph, 25);
      e2 = asr64(sx16(coef_c, 1) * p, 19);
      p = asr64(p + e1 + e2, 8) + (sx16(coef_c, 0) << 4);
      r.press = p[31:0];
      r.valid = 1'b1;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    comp_result_t want, got;
    if (rst) begin
      coef_t <= '0;
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_TEMP:    coef_t <= cfg_data;
          REG_PRESS_A: coef_a <= cfg_data;
          REG_PRESS_B: coef_b <= cfg_data;
          REG_PRESS_C: coef_c <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
      if (m_tvalid && m_tready) begin
        got.fine  = m_tdata[31:0];
        got.centi = m_tdata[58:32];
        got.press = m_tdata[90:59];
        got.valid = m_tuser[0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.fine !== got.fine)
            $display("%0t: fine_temperature exp %h act %h", $time, want.fine, got.fine);
          if (want.centi !== got.centi)
            $display("%0t: temperature_centi exp %h act %h", $time, want.centi, got.centi);
          if (want.press !== got.press)
            $display("%0t: pressure_q24_8 exp %h act %h", $time, want.press, got.press);
          if (want.valid !== got.valid)
            $display("%0t: pressure_valid exp %b act %b", $time, want.valid, got.valid);
          if (want !== got)
            fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

### dv/tb_baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation
// Drives raw sample beats under several coefficient sets (zero, typical,
// all-ones, extremes, random) with random idling on both sides, a long
// output stall and drain pauses; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation;
  import bpc_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;    // raw_temperature, raw_pressure
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // fine, centi, pressure, zero pad
  logic [0:0]       m_tuser;         // pressure_valid
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             hold_go = 1'b0;
  int               fail_count, pending;
  int               src_idle = 0, snk_idle = 0, hold_cnt = 0;

  always #5 clk = ~clk;

  baro_pressure_temp_compensation u_top (.*);
  bpc_checker u_chk (.*);

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_go) begin
      m_tready <= 1'b0;
      hold_cnt <= 400;
    end else if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rp, rt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // wait for the clock first so the last accepted beat is already counted
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_coef(reg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(logic [CFG_W-1:0] t, a, b, c);
    write_coef(REG_TEMP, t);
    write_coef(REG_PRESS_A, a);
    write_coef(REG_PRESS_B, b);
    write_coef(REG_PRESS_C, c);
  endtask

  function automatic logic [CFG_W-1:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  task automatic random_sample();
    if ($urandom_range(9) < 7)
      send_sample(20'($urandom_range(600000, 400000)), 20'($urandom_range(500000, 250000)));
    else
      send_sample(20'($urandom()), 20'($urandom()));
  endtask

  // typical calibration set
  localparam logic [CFG_W-1:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [CFG_W-1:0] TYP_A = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [CFG_W-1:0] TYP_B = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [CFG_W-1:0] TYP_C = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients are zero: divisor zero, pressure invalid
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    load_coefs(TYP_T, TYP_A, TYP_B, TYP_C);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h80000, 20'h80000);
    drain();
    load_coefs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd519888, 20'd415148);
    drain();
    load_coefs(48'h7FFF7FFF7FFF, 48'h7FFF7FFFFFFF, 48'h7FFF7FFF7FFF, 48'h7FFF7FFF7FFF);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    load_coefs(48'h800080000000, 48'h800080000001, 48'h800080008000, 48'h800080008000);
    send_sample(20'h0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h0);
    drain();
    // P1 zero forces a zero divisor under a live temperature set
    load_coefs(TYP_T, {TYP_A[47:16], 16'h0}, TYP_B, TYP_C);
    send_sample(20'd519888, 20'd415148);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin src_idle = 19; snk_idle = 82; end
        1: begin src_idle = 82; snk_idle = 19; end
        default: begin src_idle = 0; snk_idle = 0; end
      endcase
      drain();
      case (ph)
        0, 3: load_coefs(TYP_T, TYP_A, TYP_B, TYP_C);
        1: load_coefs(rand48(), rand48(), rand48(), rand48());
        2: load_coefs({TYP_T[47:16], 16'($urandom())}, TYP_A,
                      {16'($urandom()), TYP_B[31:0]}, {16'($urandom()), TYP_C[31:0]});
        4: load_coefs(rand48(), {rand48()} & 48'hFFFFFFFF000F, rand48(), rand48());
        default: load_coefs(TYP_T ^ 48'($urandom_range(255)), TYP_A, TYP_B, rand48());
      endcase
      if (ph == 2) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      repeat (180) random_sample();
    end
    drain();
    repeat (100) @(posedge clk);

    if (fail_count == 0)
      $display("** baro_pressure_temp_compensation: PASSED **");
    else
      $display("** baro_pressure_temp_compensation: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("** baro_pressure_temp_compensation: FAILED **");
    $finish;
  end

endmodule
